### rtl/core/rth_pkg.sv
package rth_pkg;

  localparam int HUE_BITS    = 15;
  localparam int SAT_BITS    = 16;
  localparam int QUOT_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;

  // sector base codes, named by the smallest component
  localparam logic [2:0] BASE_GREEN_MIN = 3'd1;
  localparam logic [2:0] BASE_RED_MIN   = 3'd3;
  localparam logic [2:0] BASE_BLUE_MIN  = 3'd5;

  typedef struct packed {
    logic [2:0] base;
    logic       neg;
    logic       grey;
  } rth_ctrl_t;

  function automatic logic [HUE_BITS-1:0] sector_offset(input logic [2:0] base);
    logic [HUE_BITS-1:0] off;
    case (base)
      BASE_GREEN_MIN: off = HUE_SECTOR;
      BASE_RED_MIN:   off = 15'd11520;
      BASE_BLUE_MIN:  off = 15'd19200;
      default:        off = '0;
    endcase
    return off;
  endfunction

endpackage

### rtl/core/rth_front.sv
module rth_front #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COMPONENT_BITS-1:0] out_mx,
  output logic [COMPONENT_BITS-1:0] out_d,
  output logic [COMPONENT_BITS-1:0] out_mag,
  output rth_pkg::rth_ctrl_t        out_ctrl
);
  import rth_pkg::*;

  logic                      held;
  logic [COMPONENT_BITS-1:0] r;
  logic [COMPONENT_BITS-1:0] g;
  logic [COMPONENT_BITS-1:0] b;
  logic [COMPONENT_BITS-1:0] mn;
  logic [COMPONENT_BITS-1:0] mx;
  logic [COMPONENT_BITS-1:0] pos;
  logic [COMPONENT_BITS-1:0] negv;
  logic [2:0]                base;

  assign in_ready  = !held || out_ready;
  assign out_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r <= red;
      g <= green;
      b <= blue;
    end
  end

  // classify: extremes, sector and delta magnitude
  always_comb begin
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (mn == r) begin
      base = BASE_RED_MIN;
      pos  = g;
      negv = b;
    end else if (mn == g) begin
      base = BASE_GREEN_MIN;
      pos  = b;
      negv = r;
    end else begin
      base = BASE_BLUE_MIN;
      pos  = r;
      negv = g;
    end
  end

  assign out_mx        = mx;
  assign out_d         = mx - mn;
  assign out_mag       = (pos >= negv) ? (pos - negv) : (negv - pos);
  assign out_ctrl.base = base;
  assign out_ctrl.neg  = (pos < negv);
  assign out_ctrl.grey = (mx == mn);

endmodule

### rtl/core/rth_queue.sv
module rth_queue #(
  parameter int DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_BITS-1:0] in_data,
  input  rth_pkg::rth_ctrl_t   in_ctrl,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] out_data,
  output rth_pkg::rth_ctrl_t   out_ctrl
);
  import rth_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] data_mem [QUEUE_DEPTH];
  rth_ctrl_t            ctrl_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 push;
  logic                 pop;

  assign in_ready  = (count != CNT_BITS'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = data_mem[rd_ptr];
  assign out_ctrl  = ctrl_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_mem[wr_ptr] <= in_data;
      ctrl_mem[wr_ptr] <= in_ctrl;
    end
  end

endmodule

### rtl/core/rth_back.sv
module rth_back #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_mx,
  input  logic [COMPONENT_BITS-1:0] in_d,
  input  logic [COMPONENT_BITS-1:0] in_mag,
  input  rth_pkg::rth_ctrl_t        in_ctrl,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rth_pkg::HUE_BITS-1:0] hue,
  output logic [rth_pkg::SAT_BITS-1:0] saturation,
  output logic [COMPONENT_BITS-1:0] brightness
);
  import rth_pkg::*;

  localparam int W  = COMPONENT_BITS + QUOT_BITS;
  localparam int NS = QUOT_BITS;

  logic                      advance;
  logic [NS:0]               vld;
  logic [W-1:0]              rem_h [NS+1];
  logic [W-1:0]              rem_s [NS+1];
  logic [QUOT_BITS-1:0]      quo_h [NS+1];
  logic [QUOT_BITS-1:0]      quo_s [NS+1];
  logic [COMPONENT_BITS-1:0] dv    [NS+1];
  logic [COMPONENT_BITS-1:0] mxv   [NS+1];
  rth_ctrl_t                 ctl   [NS+1];
  logic [W-1:0]              num_h;
  logic [W-1:0]              num_s;
  logic [HUE_BITS-1:0]       off;
  logic [HUE_BITS-1:0]       qh;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // 3840*mag and 65535*d as shift and subtract
  assign num_h = (W'(in_mag) << 12) - (W'(in_mag) << 8);
  assign num_s = (W'(in_d) << QUOT_BITS) - W'(in_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      vld       <= {vld[NS-1:0], in_valid};
      out_valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_h[0] <= num_h;
      rem_s[0] <= num_s;
      quo_h[0] <= '0;
      quo_s[0] <= '0;
      dv[0]    <= in_d;
      mxv[0]   <= in_mx;
      ctl[0]   <= in_ctrl;
      // one quotient bit per stage for both dividers
      for (int k = 1; k <= NS; k++) begin
        dv[k]  <= dv[k-1];
        mxv[k] <= mxv[k-1];
        ctl[k] <= ctl[k-1];
        if (rem_h[k-1] >= (W'(dv[k-1]) << (NS - k))) begin
          rem_h[k] <= rem_h[k-1] - (W'(dv[k-1]) << (NS - k));
          quo_h[k] <= quo_h[k-1] | (QUOT_BITS'(1) << (NS - k));
        end else begin
          rem_h[k] <= rem_h[k-1];
          quo_h[k] <= quo_h[k-1];
        end
        if (rem_s[k-1] >= (W'(mxv[k-1]) << (NS - k))) begin
          rem_s[k] <= rem_s[k-1] - (W'(mxv[k-1]) << (NS - k));
          quo_s[k] <= quo_s[k-1] | (QUOT_BITS'(1) << (NS - k));
        end else begin
          rem_s[k] <= rem_s[k-1];
          quo_s[k] <= quo_s[k-1];
        end
      end
    end
  end

  assign off = sector_offset(ctl[NS].base);
  assign qh  = quo_h[NS][HUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      brightness <= mxv[NS];
      if (ctl[NS].grey) begin
        hue        <= '0;
        saturation <= '0;
      end else begin
        hue        <= ctl[NS].neg ? (off + qh) : (off - qh);
        saturation <= quo_s[NS];
      end
    end
  end

endmodule

### rtl/core/rgb_to_hsv.sv
// RGB to HSV pixel converter. Takes pixels on s_* and gives hue in 1/64 degree
// (0..23040), saturation scaled to 65535 and value (the largest component) on m_*, one item
// out for each item in. Sustained rate is one item per cycle while m_tready stays high. The path
// runs through one classify register, the 4-entry queue, one product stage,
// 16 stages of the pair of pipelined restoring dividers (one quotient bit each) and the output
// register. Grey pixels give hue and saturation 0. Reset has no effect on results.
module rgb_to_hsv #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // red, green, blue
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hue, saturation, brightness
  output logic [((rth_pkg::HUE_BITS+rth_pkg::SAT_BITS+COMPONENT_BITS+7)/8)*8-1:0] m_tdata
);
  import rth_pkg::*;

  localparam int CB     = COMPONENT_BITS;
  localparam int OUT_W  = ((HUE_BITS + SAT_BITS + CB + 7) / 8) * 8;
  localparam int DATA_W = 3 * CB;

  logic                f_valid;
  logic                f_ready;
  logic [CB-1:0]       f_mx;
  logic [CB-1:0]       f_d;
  logic [CB-1:0]       f_mag;
  rth_ctrl_t           f_ctrl;
  logic                q_valid;
  logic                q_ready;
  logic [DATA_W-1:0]   q_data;
  rth_ctrl_t           q_ctrl;
  logic [HUE_BITS-1:0] hue;
  logic [SAT_BITS-1:0] saturation;
  logic [CB-1:0]       brightness;

  rth_front #(.COMPONENT_BITS(CB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[CB-1:0]),
    .green     (s_tdata[2*CB-1:CB]),
    .blue      (s_tdata[3*CB-1:2*CB]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_mx    (f_mx),
    .out_d     (f_d),
    .out_mag   (f_mag),
    .out_ctrl  (f_ctrl)
  );

  rth_queue #(.DATA_BITS(DATA_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_mag, f_d, f_mx}),
    .in_ctrl   (f_ctrl),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data),
    .out_ctrl  (q_ctrl)
  );

  rth_back #(.COMPONENT_BITS(CB)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_mx      (q_data[CB-1:0]),
    .in_d       (q_data[2*CB-1:CB]),
    .in_mag     (q_data[3*CB-1:2*CB]),
    .in_ctrl    (q_ctrl),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  assign m_tdata = OUT_W'({brightness, saturation, hue});

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hue <= 15'd23040))
    else $error("hue out of range");

  a_grey_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (saturation == '0)) |-> (hue == '0))
    else $error("zero saturation with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (brightness == '0)) |-> (saturation == '0))
    else $error("black pixel with nonzero saturation");
`endif

endmodule

### tb/sv/tb.sv
module tb;
  import rth_pkg::*;

  localparam int COMPONENT_BITS = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic                pad;
    logic [7:0]          brightness;
    logic [SAT_BITS-1:0] saturation;
    logic [HUE_BITS-1:0] hue;
  } hsv_t;

  typedef struct {
    pixel_t      px;
    int unsigned gap;
    bit          drain;
  } send_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   s_tvalid = 1'b0;
  logic   s_tready;
  // red, green, blue
  pixel_t s_tdata = '0;
  logic   m_tvalid;
  logic   m_tready = 1'b0;
  // hue, saturation, brightness
  hsv_t   m_tdata;

  send_t       pixel_q[$];
  hsv_t        hsv_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned pixel_cnt = 0;
  hsv_t        want;

  rgb_to_hsv #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic hsv_t hsv_of(pixel_t p);
    int unsigned r, g, b, mn, mx, d, base, pos, neg, sector, hue, sat;
    hsv_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    sector = HUE_SECTOR;
    mn = r;
    mx = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    hue = 0;
    sat = 0;
    if (mx != mn) begin
      d = mx - mn;
      // ties for the smallest go to red, then green
      if (mn == r) begin
        base = BASE_RED_MIN;
        pos = g;
        neg = b;
      end else if (mn == g) begin
        base = BASE_GREEN_MIN;
        pos = b;
        neg = r;
      end else begin
        base = BASE_BLUE_MIN;
        pos = r;
        neg = g;
      end
      if (pos >= neg) hue = sector * base - (sector * (pos - neg)) / d;
      else hue = sector * base + (sector * (neg - pos)) / d;
      sat = (65535 * d) / mx;
    end
    res = '0;
    res.hue = hue[HUE_BITS-1:0];
    res.saturation = sat[SAT_BITS-1:0];
    res.brightness = mx[7:0];
    return res;
  endfunction

  task automatic add_pixel(int unsigned r, int unsigned g, int unsigned b, bit drain);
    send_t e;
    int unsigned sel;
    e.px.red = r[7:0];
    e.px.green = g[7:0];
    e.px.blue = b[7:0];
    e.drain = drain;
    sel = $urandom_range(99);
    // every fourth stretch of 100 items runs back to back
    if ((pixel_cnt / 100) % 4 == 1 || sel < 60) e.gap = 0;
    else if (sel < 92) e.gap = $urandom_range(3, 1);
    else e.gap = $urandom_range(40, 6);
    pixel_q.push_back(e);
    pixel_cnt++;
  endtask

  task automatic add_random_pixel(bit drain);
    int unsigned sel, r, g, b, v;
    sel = $urandom_range(99);
    r = $urandom_range(255);
    g = $urandom_range(255);
    b = $urandom_range(255);
    if (sel >= 60 && sel < 78) begin
      // near grey
      v = $urandom_range(255);
      r = (v + $urandom_range(2)) % 256;
      g = (v + $urandom_range(2)) % 256;
      b = (v + $urandom_range(2)) % 256;
    end else if (sel >= 78 && sel < 90) begin
      // two components equal
      case ($urandom_range(2))
        0: g = r;
        1: b = g;
        default: r = b;
      endcase
    end else if (sel >= 90) begin
      r = $urandom_range(1) ? 255 : 0;
      g = $urandom_range(1) ? 255 : 0;
      b = $urandom_range(1) ? 255 : $urandom_range(255);
    end
    add_pixel(r, g, b, drain);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    if (err_cnt < 50) $display("mismatch %s: got %0d, expected %0d", what, got, exp_val);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      idle_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        hsv_q.push_back(hsv_of(s_tdata));
        pixel_q.delete(0);
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() == 0 || (pixel_q[0].drain && hsv_q.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= pixel_q[0].px;
          idle_left = pixel_q[0].gap;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hsv_q.size() == 0) begin
          report_mismatch("unexpected item, hue", m_tdata.hue, 0);
        end else begin
          want = hsv_q.pop_front();
          if (m_tdata.hue !== want.hue)
            report_mismatch("hue", m_tdata.hue, want.hue);
          if (m_tdata.saturation !== want.saturation)
            report_mismatch("saturation", m_tdata.saturation, want.saturation);
          if (m_tdata.brightness !== want.brightness)
            report_mismatch("brightness", m_tdata.brightness, want.brightness);
          if (m_tdata.pad !== want.pad)
            report_mismatch("padding", m_tdata.pad, want.pad);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (cycle_cnt[11:10] != 2'd0 && $urandom_range(3) == 0) begin
          if ($urandom_range(99) < 85) stall_left = $urandom_range(3, 1);
          else stall_left = $urandom_range(40, 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // grey, black and white
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(128, 128, 128, 1'b0);
    add_pixel(1, 1, 1, 1'b0);
    // primaries and secondaries
    add_pixel(255, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 1'b0);
    add_pixel(0, 0, 255, 1'b0);
    add_pixel(255, 255, 0, 1'b0);
    add_pixel(0, 255, 255, 1'b0);
    add_pixel(255, 0, 255, 1'b0);
    // smallest-component ties and one-step deltas
    add_pixel(1, 0, 0, 1'b0);
    add_pixel(0, 0, 1, 1'b0);
    add_pixel(0, 1, 0, 1'b0);
    add_pixel(254, 255, 255, 1'b0);
    add_pixel(255, 254, 255, 1'b0);
    add_pixel(255, 255, 254, 1'b0);
    add_pixel(1, 2, 3, 1'b0);
    add_pixel(3, 2, 1, 1'b0);
    add_pixel(200, 100, 50, 1'b0);
    add_pixel(50, 100, 200, 1'b0);
    add_pixel(255, 1, 0, 1'b0);
    add_pixel(128, 255, 127, 1'b0);
    add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    add_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    for (int i = 0; i < 1330; i++) add_random_pixel(i % 300 == 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pixel_q.size() == 0 && !s_tvalid);
    wait (hsv_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
